// ----- rtl/swmec_pkg.sv -----
// ----------------------------------------------------------------------------
// swmec_pkg: shared types for the slice window mean block
// Item types of both channels and the request/response of the divider.
// ----------------------------------------------------------------------------
package swmec_pkg;

    localparam int DIV_W = 20;   // dividend width of the shared divider
    localparam int CW    = 8;    // width of window counts and divisors

    // configuration register indexes
    localparam logic [1:0] REG_HALF_SPAN = 2'd0;
    localparam logic [1:0] REG_SKIP      = 2'd1;
    localparam logic [1:0] REG_ENDS      = 2'd2;
    localparam logic [1:0] REG_PIXELS    = 2'd3;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] slice_index;
        logic [19:0] pixel_index;
        logic [7:0]  mean_value;
        logic [13:0] window_sum;
        logic [5:0]  summed_count;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CW-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [CW-1:0]    rem;
    } t_div_rsp;

endpackage

// ----- rtl/swmec_div.sv -----
// ----------------------------------------------------------------------------
// swmec_div: iterative restoring divider
// One quotient bit per cycle; done pulses once with quotient and remainder.
// ----------------------------------------------------------------------------
module swmec_div
    import swmec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int NW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [NW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [CW:0]      r_rem;
    logic [CW-1:0]    r_dvs;
    logic [CW:0]      shifted;
    logic             fits;

    always_comb begin
        shifted = {r_rem[CW-1:0], r_quo[DIV_W-1]};
        fits    = shifted >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == NW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DIV_W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                r_rem <= fits ? shifted - {1'b0, r_dvs} : shifted;
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[CW-1:0];

endmodule

// ----- rtl/slice_window_mean_excluding_center.sv -----
// ----------------------------------------------------------------------------
// slice_window_mean_excluding_center: temporal window mean, center left out
// Per pixel sliding window over a stack of slices with a center exclusion.
// ----------------------------------------------------------------------------
// Pixels of a slice stack arrive in raster order; for each position the block
// keeps a ring of the last 2*S+1 values and a running sum, and emits the mean
// of the center slice with the center group left out (plus the front and tail
// slices when ends are enabled; a flush item emits the tail of one position).
// After reset the block zeroes every entry of the running sum memory and
// takes no item meanwhile; configuration writes are taken always.
// The block handles one item at a time. Each item first runs a slice-modulo
// through the shared 20-step divider; every front or tail result then costs
// one store read, one mean division and the output handshake, the center
// result a mean division and the handshake, and each center-group slice a
// store read. The serial divider sets most of the cost of an item.
// ----------------------------------------------------------------------------
module slice_window_mean_excluding_center
    import swmec_pkg::*;
#(
    parameter int MAX_HALF_SPAN = 16,
    parameter int MAX_PIXELS    = 1048576,
    parameter int MAX_SLICES    = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    localparam int WIN_MAX = 2 * MAX_HALF_SPAN + 1;
    localparam int PW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PCW     = $clog2(MAX_PIXELS + 1);
    localparam int XW      = (PCW > 21) ? PCW : 21;
    localparam int SW      = $clog2(MAX_SLICES);
    localparam int MW      = (SW > CW) ? SW : CW;
    localparam int AW      = $clog2(MAX_PIXELS * WIN_MAX);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MODST, S_MOD, S_WR, S_CEN0, S_RD, S_USE,
        S_DIVST, S_DIV, S_OUT, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_FRONT, PH_CEN, PH_OLD, PH_TAIL
    } t_phase;

    // (r + w - d) mod w for r < w and d <= w
    function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] r,
                                              input logic [CW-1:0] d,
                                              input logic [CW-1:0] w);
        logic [CW:0] t;
        t = {1'b0, r} + {1'b0, w} - {1'b0, d};
        if (t >= {1'b0, w}) begin
            t = t - {1'b0, w};
        end
        return t[CW-1:0];
    endfunction

    t_state           r_state;
    t_phase           r_phase;

    // configuration
    logic [4:0]       r_cfg_hs;
    logic [5:0]       r_cfg_skip;
    logic             r_cfg_ends;
    logic [20:0]      r_cfg_pps;

    // stack position
    logic [PW-1:0]    r_pos;
    logic [SW-1:0]    r_slices;
    logic [PW-1:0]    r_clr;

    // item context
    logic             r_cmd;
    logic [7:0]       r_val;
    logic [PW-1:0]    r_p;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_rslot;
    logic [CW-1:0]    r_rd_slot;
    logic [CW-1:0]    r_i;
    logic [13:0]      r_sum;
    logic [13:0]      r_csum;

    // result being formed
    logic [SW-1:0]    r_em_slice;
    logic [13:0]      r_em_sum;
    logic [CW-1:0]    r_em_cnt;
    logic             r_em_last;

    logic             r_ov;
    t_out_item        r_out;

    // memories
    logic [7:0]       st_mem [MAX_PIXELS * WIN_MAX];
    logic [13:0]      sm_mem [MAX_PIXELS];
    logic [7:0]       r_st_q;
    logic [13:0]      r_sm_q;

    // derived configuration
    logic [CW-1:0]    span, win, span2, skip, h, excl;
    logic [XW-1:0]    pps;
    logic [XW-1:0]    cfg_pps_x;
    logic [PW-1:0]    p_eff;
    logic             s_ge_2span, s_eq_2span, s_ge_win, last_pos;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    always_comb begin
        if (r_cfg_hs == 5'd0) begin
            span = CW'(1);
        end else if (CW'(r_cfg_hs) > CW'(MAX_HALF_SPAN)) begin
            span = CW'(MAX_HALF_SPAN);
        end else begin
            span = CW'(r_cfg_hs);
        end
        span2 = span << 1;
        win   = span2 + CW'(1);
        skip  = (CW'(r_cfg_skip) > span2) ? span2 : CW'(r_cfg_skip);
        h     = skip >> 1;
        excl  = (skip != '0) ? ((h << 1) + CW'(1)) : '0;

        cfg_pps_x = XW'(r_cfg_pps);
        if (cfg_pps_x == '0) begin
            pps = XW'(1);
        end else if (cfg_pps_x > XW'(MAX_PIXELS)) begin
            pps = XW'(MAX_PIXELS);
        end else begin
            pps = cfg_pps_x;
        end
        p_eff = (XW'(r_pos) >= pps) ? '0 : r_pos;

        s_ge_2span = MW'(r_slices) >= MW'(span2);
        s_eq_2span = MW'(r_slices) == MW'(span2);
        s_ge_win   = MW'(r_slices) >= MW'(win);
        last_pos   = (XW'(r_p) + XW'(1)) >= pps;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // shared divider: slice modulo window, then each mean
    always_comb begin
        div_req.start    = (r_state == S_MODST) || (r_state == S_DIVST);
        div_req.dividend = (r_state == S_MODST) ? DIV_W'(r_slices) : DIV_W'(r_em_sum);
        div_req.divisor  = (r_state == S_MODST) ? win : r_em_cnt;
    end

    swmec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // slice store: written once per pixel item, read one slot at a time
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            st_mem[r_base + AW'(r_rslot)] <= r_val;
        end
        r_st_q <= st_mem[r_base + AW'(r_rd_slot)];
    end

    // running sums: zeroed by the clearing pass, rewritten at item end
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            sm_mem[r_clr] <= '0;
        end else if (r_state == S_FIN) begin
            sm_mem[r_p] <= (r_cmd == CMD_FLUSH) ? 14'd0 : r_sum;
        end
        r_sm_q <= sm_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_phase    <= PH_FRONT;
            r_cfg_hs   <= 5'd1;
            r_cfg_skip <= 6'd1;
            r_cfg_ends <= 1'b1;
            r_cfg_pps  <= 21'd1048576;
            r_pos      <= '0;
            r_slices   <= '0;
            r_clr      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_HALF_SPAN: r_cfg_hs   <= i_cfg_data[4:0];
                    REG_SKIP:      r_cfg_skip <= i_cfg_data[5:0];
                    REG_ENDS:      r_cfg_ends <= i_cfg_data[0];
                    REG_PIXELS:    r_cfg_pps  <= i_cfg_data;
                    default:       ;
                endcase
            end

            // drop the result once taken; S_OUT refills the register itself
            if (r_ov && i_out_ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PW'(MAX_PIXELS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_item.command;
                        r_val   <= i_in_item.pixel_value;
                        r_p     <= p_eff;
                        r_base  <= AW'(p_eff) * AW'(WIN_MAX);
                        r_pos   <= p_eff;
                        r_state <= S_MODST;
                    end
                end
                S_MODST: r_state <= S_MOD;
                S_MOD: begin
                    if (div_rsp.done) begin
                        r_rslot <= div_rsp.rem;
                        if (r_cmd == CMD_PIXEL) begin
                            r_state <= S_WR;
                        end else begin
                            r_sum <= r_sm_q;
                            if (r_cfg_ends && s_ge_win) begin
                                r_phase   <= PH_TAIL;
                                r_i       <= '0;
                                r_rd_slot <= mod_sub(div_rsp.rem, span, win);
                                r_state   <= S_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_WR: begin
                    // store the new value and add it to the running sum
                    r_sum <= r_sm_q + 14'(r_val);
                    if (s_ge_2span) begin
                        if (s_eq_2span && r_cfg_ends) begin
                            r_phase   <= PH_FRONT;
                            r_i       <= '0;
                            r_rd_slot <= '0;
                            r_state   <= S_RD;
                        end else begin
                            r_state <= S_CEN0;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_CEN0: begin
                    r_csum  <= r_sum;
                    r_phase <= PH_CEN;
                    r_i     <= '0;
                    if (excl != '0) begin
                        r_rd_slot <= mod_sub(r_rslot, span + h, win);
                        r_state   <= S_RD;
                    end else begin
                        r_em_slice <= r_slices - SW'(span);
                        r_em_sum   <= r_sum;
                        r_em_cnt   <= win;
                        r_em_last  <= 1'b1;
                        r_state    <= S_DIVST;
                    end
                end
                S_RD: r_state <= S_USE;
                S_USE: begin
                    unique case (r_phase)
                        PH_FRONT: begin
                            r_em_slice <= SW'(r_i);
                            r_em_sum   <= r_sum - 14'(r_st_q);
                            r_em_cnt   <= span2;
                            r_em_last  <= 1'b0;
                            r_state    <= S_DIVST;
                        end
                        PH_CEN: begin
                            // subtract one excluded center slice
                            r_csum <= r_csum - 14'(r_st_q);
                            r_i    <= r_i + 1'b1;
                            if (r_i + CW'(1) < excl) begin
                                r_rd_slot <= mod_sub(r_rslot, span + h - r_i - CW'(1), win);
                                r_state   <= S_RD;
                            end else begin
                                r_em_slice <= r_slices - SW'(span);
                                r_em_sum   <= r_csum - 14'(r_st_q);
                                r_em_cnt   <= win - excl;
                                r_em_last  <= 1'b1;
                                r_state    <= S_DIVST;
                            end
                        end
                        PH_OLD: begin
                            // retire the oldest slice from the running sum
                            r_sum   <= r_sum - 14'(r_st_q);
                            r_state <= S_FIN;
                        end
                        PH_TAIL: begin
                            r_em_slice <= r_slices - SW'(span) + SW'(r_i);
                            r_em_sum   <= r_sum - 14'(r_st_q);
                            r_em_cnt   <= span2 - CW'(1);
                            r_em_last  <= (r_i + CW'(1) == span);
                            r_state    <= S_DIVST;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_DIVST: r_state <= S_DIV;
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_ov || i_out_ready) begin
                        r_ov                   <= 1'b1;
                        r_out.slice_index      <= 16'(r_em_slice);
                        r_out.pixel_index      <= 20'(r_p);
                        r_out.mean_value       <= (r_em_cnt == '0) ? 8'd0 : div_rsp.quot[7:0];
                        r_out.window_sum       <= (r_em_cnt == '0) ? 14'd0 : r_em_sum;
                        r_out.summed_count     <= r_em_cnt[5:0];
                        r_out.last_of_run      <= r_em_last;
                        unique case (r_phase)
                            PH_FRONT: begin
                                r_i <= r_i + 1'b1;
                                if (r_i + CW'(1) < span) begin
                                    r_rd_slot <= r_i + CW'(1);
                                    r_state   <= S_RD;
                                end else begin
                                    r_state <= S_CEN0;
                                end
                            end
                            PH_CEN: begin
                                r_phase   <= PH_OLD;
                                r_rd_slot <= mod_sub(r_rslot, span2, win);
                                r_state   <= S_RD;
                            end
                            PH_TAIL: begin
                                r_i <= r_i + 1'b1;
                                if (r_i + CW'(1) < span) begin
                                    r_rd_slot <= mod_sub(r_rslot, span - r_i - CW'(1), win);
                                    r_state   <= S_RD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_FIN: begin
                    // advance the raster position, wrap into the next slice
                    if (last_pos) begin
                        r_pos <= '0;
                        if ((r_cmd == CMD_FLUSH)
                            || (MW'(r_slices) + MW'(1) == MW'(MAX_SLICES))) begin
                            r_slices <= '0;
                        end else begin
                            r_slices <= r_slices + 1'b1;
                        end
                    end else begin
                        r_pos <= r_p + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // no input while the sum memory is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    // a waiting result is never dropped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // the mean never exceeds the sum over its count
    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.summed_count != 6'd0) |->
        (22'(o_out_item.mean_value) * 22'(o_out_item.summed_count)
            <= 22'(o_out_item.window_sum)))
        else $error("mean out of range");

endmodule

// ----- test/swmec_checker.sv -----
// ----------------------------------------------------------------------------
// swmec_checker: result predictor and scoreboard for the slice window mean
// Watches the config port and both channels, predicts the results of every
// accepted item and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module swmec_checker
    import swmec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SPAN_CAP  = 16;
    localparam int WIN_CAP   = 2 * SPAN_CAP + 1;
    localparam int PIX_CAP   = 1048576;
    localparam int SLICE_CAP = 65536;

    logic [4:0]  half_span;
    logic [5:0]  center_skip;
    logic        ends_on;
    logic [20:0] pixels_per_slice;

    logic [7:0]  ring_mem [int];
    logic [13:0] sum_mem  [int];
    int          slices_done;
    int          position;

    t_out_item   means_due [$];

    assign o_pending = means_due.size();

    function automatic int ring_at(int p, int slice, int win);
        int key;
        key = p * WIN_CAP + (slice % win);
        return ring_mem.exists(key) ? int'(ring_mem[key]) : 0;
    endfunction

    function automatic int sum_at(int p);
        return sum_mem.exists(p) ? int'(sum_mem[p]) : 0;
    endfunction

    function automatic t_out_item make_mean(int slice, int p, int sum, int cnt);
        t_out_item r;
        int s;
        s = sum & 'h3FFF;
        if (cnt == 0) s = 0;
        r.slice_index  = 16'(slice);
        r.pixel_index  = 20'(p);
        r.mean_value   = 8'(cnt != 0 ? s / cnt : 0);
        r.window_sum   = 14'(s);
        r.summed_count = 6'(cnt);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic predict_means(t_in_item it);
        t_out_item batch [$];
        int span, win, skip, h, excl, pps, p, s, sum, c, csum;
        span = (half_span < 1) ? 1 : int'(half_span);
        if (span > SPAN_CAP) span = SPAN_CAP;
        win  = 2 * span + 1;
        skip = (center_skip > 2 * span) ? 2 * span : int'(center_skip);
        h    = skip / 2;
        excl = (skip != 0) ? 2 * h + 1 : 0;
        pps  = (pixels_per_slice < 1) ? 1 : int'(pixels_per_slice);
        if (pps > PIX_CAP) pps = PIX_CAP;
        if (position >= pps) position = 0;
        p = position;
        s = slices_done;
        if (it.command == CMD_PIXEL) begin
            ring_mem[p * WIN_CAP + (s % win)] = it.pixel_value;
            sum = (sum_at(p) + int'(it.pixel_value)) & 'h3FFF;
            if (s >= 2 * span) begin
                c = s - span;
                csum = sum;
                if (s == 2 * span && ends_on) begin
                    for (int j = 0; j < span; j++)
                        batch.push_back(make_mean(j, p, sum - ring_at(p, j, win), 2 * span));
                end
                if (excl != 0) begin
                    for (int k = c - h; k <= c + h; k++) csum -= ring_at(p, k, win);
                end
                batch.push_back(make_mean(c, p, csum, win - excl));
                sum = (sum - ring_at(p, s - 2 * span, win)) & 'h3FFF;
            end
            sum_mem[p] = 14'(sum);
            position = p + 1;
            if (position >= pps) begin
                position = 0;
                slices_done = (s + 1) % SLICE_CAP;
            end
        end else begin
            if (ends_on && s >= 2 * span + 1) begin
                sum = sum_at(p);
                for (int j = s - span; j < s; j++)
                    batch.push_back(make_mean(j, p, sum - ring_at(p, j, win), 2 * span - 1));
            end
            sum_mem[p] = '0;
            position = p + 1;
            if (position >= pps) begin
                position = 0;
                slices_done = 0;
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i]) means_due.push_back(batch[i]);
    endtask

    task automatic report(string what);
        $display("mismatch: %s", what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            half_span        = 5'd1;
            center_skip      = 6'd1;
            ends_on          = 1'b1;
            pixels_per_slice = 21'd1048576;
            ring_mem.delete();
            sum_mem.delete();
            slices_done = 0;
            position    = 0;
            means_due.delete();
            o_fail_count = 0;
        end else begin
            // config is meant to be written only while idle (nothing here enforces it), so apply it first
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HALF_SPAN: half_span        = i_cfg_data[4:0];
                    REG_SKIP:      center_skip      = i_cfg_data[5:0];
                    REG_ENDS:      ends_on          = i_cfg_data[0];
                    REG_PIXELS:    pixels_per_slice = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_means(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (means_due.size() == 0) begin
                    report($sformatf("unexpected result %p", i_out_item));
                end else begin
                    want = means_due.pop_front();
                    if (i_out_item.slice_index != want.slice_index)
                        report($sformatf("slice_index %0d want %0d",
                                         i_out_item.slice_index, want.slice_index));
                    if (i_out_item.pixel_index != want.pixel_index)
                        report($sformatf("pixel_index %0d want %0d",
                                         i_out_item.pixel_index, want.pixel_index));
                    if (i_out_item.mean_value != want.mean_value)
                        report($sformatf("mean_value %0d want %0d",
                                         i_out_item.mean_value, want.mean_value));
                    if (i_out_item.window_sum != want.window_sum)
                        report($sformatf("window_sum %0d want %0d",
                                         i_out_item.window_sum, want.window_sum));
                    if (i_out_item.summed_count != want.summed_count)
                        report($sformatf("summed_count %0d want %0d",
                                         i_out_item.summed_count, want.summed_count));
                    if (i_out_item.last_of_run != want.last_of_run)
                        report($sformatf("last_of_run %0d want %0d",
                                         i_out_item.last_of_run, want.last_of_run));
                end
            end
        end
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the slice window mean block
// Feeds slice stacks of small images under many window settings, with random
// gaps on both channels and one long output stall; the checker does the rest.
// ----------------------------------------------------------------------------
module testbench;
    import swmec_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;   // watchdog bound, sized for the clearing pass
    localparam int SETTLE      = 300;       // covers a pixel item with no result
    localparam int ITEM_GOAL   = 410;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;
    int          fail_count;
    int          pending;

    int          items_sent;
    int          cycles;
    bit          no_gaps;       // a stretch with no idling on either side
    int          hold_asked;    // bumped by the stimulus to request a long stall
    int          hold_done;
    int          hold_left;
    int          pix_now;       // current pixels per slice, for whole stacks

    slice_window_mean_excluding_center u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    swmec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end a hung run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long stall on request so the
    // block fills up and has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = 600;
            out_ready <= 1'b0;
        end else if (no_gaps) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 12);
        end
    end

    // Offer one item and hold it until accepted; valid stays high into the
    // next item unless a random gap is drawn.
    task automatic send_item(logic cmd, logic [7:0] value);
        while (!no_gaps && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, pixel_value: value};
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        if (items_sent == 120) hold_asked++;
    endtask

    // Drop valid, wait until every result is in and the block has gone quiet.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [20:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == REG_PIXELS) pix_now = (value == 0) ? 1 : int'(value);
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Whole slices in raster order, then optionally a flush of every position.
    task automatic run_stack(int slices, bit flush);
        for (int s = 0; s < slices; s++)
            for (int p = 0; p < pix_now; p++) send_item(CMD_PIXEL, pick_value());
        if (flush)
            for (int p = 0; p < pix_now; p++) send_item(CMD_FLUSH, 8'($urandom));
    endtask

    initial begin
        int span, slices;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_gaps    = 1'b0;
        hold_asked = 0;
        hold_done  = 0;
        hold_left  = 0;
        items_sent = 0;
        cycles     = 0;
        pix_now    = 1048576;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one pixel per slice, span 1; extremes of the values.
        write_reg(REG_PIXELS, 21'd1);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd0);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_FLUSH, 8'd0);
        drain();
        // Whole window excluded: skip at 2*span gives an empty sum.
        write_reg(REG_SKIP, 21'd2);
        run_stack(4, 1'b1);
        drain();
        // Ends off and no exclusion; short stack flush emits nothing.
        write_reg(REG_ENDS, 21'd0);
        write_reg(REG_SKIP, 21'd0);
        run_stack(3, 1'b1);
        run_stack(2, 1'b1);
        drain();
        // Position beyond slice: lower pixels per slice mid-slice.
        write_reg(REG_ENDS, 21'd1);
        write_reg(REG_SKIP, 21'd63);
        write_reg(REG_HALF_SPAN, 21'd0);
        write_reg(REG_PIXELS, 21'd4);
        run_stack(0, 1'b0);
        send_item(CMD_PIXEL, 8'd7);
        send_item(CMD_PIXEL, 8'd9);
        send_item(CMD_PIXEL, 8'd11);
        drain();
        write_reg(REG_PIXELS, 21'd2);
        run_stack(3, 1'b1);
        drain();
        // Largest slice size: a few pixels only, then shrink to restart.
        write_reg(REG_PIXELS, 21'h1FFFFF);
        for (int i = 0; i < 3; i++) send_item(CMD_PIXEL, pick_value());
        drain();
        write_reg(REG_PIXELS, 21'd0);
        run_stack(2, 1'b1);
        drain();
        // Widest window with one pixel per slice.
        write_reg(REG_HALF_SPAN, 21'd16);
        write_reg(REG_SKIP, 21'd32);
        write_reg(REG_PIXELS, 21'd1);
        run_stack(34, 1'b1);
        drain();

        // Random stacks under changing settings.
        while (items_sent < ITEM_GOAL) begin
            no_gaps = (items_sent > 250 && items_sent < 330);
            span = ($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(3);
            write_reg(REG_HALF_SPAN, 21'(span));
            write_reg(REG_SKIP, 21'($urandom_range(63)));
            write_reg(REG_ENDS, 21'($urandom_range(1)));
            write_reg(REG_PIXELS, 21'(span > 3 ? 1 : $urandom_range(4)));
            if (span == 0) span = 1;
            slices = ($urandom_range(5) == 0) ? $urandom_range(2 * span)
                                              : 2 * span + 1 + $urandom_range(3);
            run_stack(slices, $urandom_range(7) != 0);
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/swmec_pkg.sv
rtl/swmec_div.sv
rtl/slice_window_mean_excluding_center.sv
test/swmec_checker.sv
test/testbench.sv
